### hw/rtl/shmh_pkg.sv
// ----------------------------------------------------------------------------
// shmh_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package shmh_pkg;

  localparam int unsigned CntW = 61;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COMP,
    ST_PAD,
    ST_ZERO,
    ST_LEN0,
    ST_LEN1,
    ST_OUT
  } state_e;

  localparam word_t IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t sig0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t sig1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t bsig0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

### hw/rtl/sha256_message_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher_top
// Byte-serial SHA-256: bytes packed into a 16-word block memory, padding and
// length written word by word, digest emitted as eight words.
// ----------------------------------------------------------------------------
// One byte per cycle is taken while the hasher is idle (in_stall_o low).
// A full block stalls input for the memory read, the round-engine rounds
// and the chaining add. A last transaction adds the padding writes,
// one or two compressions, then eight output words.
// Reset loads the initial hash values and clears the byte count.
module sha256_message_hasher_top
  import shmh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        final_word_o
);

  state_e            state_q, state_d;
  state_e            ret_q, ret_d;
  word_t             chain_q [8];
  logic [CntW-1:0]   count_q, count_d;
  logic [23:0]       acc_q;
  logic [3:0]        ptr_q, ptr_d;
  logic              ext_q, ext_d;
  logic [2:0]        oidx_q;
  word_t             mem_q [16];
  word_t             rdata_q;
  logic              mem_we;
  logic [3:0]        waddr;
  word_t             wdata;
  word_t             padword;
  logic [3:0]        wi;
  logic              in_acc;
  logic              out_acc;
  logic              comp_start;
  logic              comp_done;
  logic [3:0]        raddr;
  word_t             vars [8];

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign wi      = count_q[5:2];

  always_comb begin
    case (count_q[1:0])
      2'd0:    padword = 32'h8000_0000;
      2'd1:    padword = {acc_q[7:0], 8'h80, 16'h0000};
      2'd2:    padword = {acc_q[15:0], 8'h80, 8'h00};
      default: padword = {acc_q[23:0], 8'h80};
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    ptr_d   = ptr_q;
    ext_d   = ext_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (has_byte_i && (count_q[5:0] == 6'd63)) begin
            state_d = ST_LOAD;
            ret_d   = last_byte_i ? ST_PAD : ST_IDLE;
          end else if (last_byte_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_LOAD: state_d = ST_COMP;
      ST_COMP: begin
        if (comp_done) begin
          state_d = ret_q;
        end
      end
      ST_PAD: begin
        if (wi == 4'd15) begin
          state_d = ST_LOAD;
          ret_d   = ST_ZERO;
          ptr_d   = 4'd0;
          ext_d   = 1'b0;
        end else if (wi == 4'd14) begin
          state_d = ST_ZERO;
          ptr_d   = 4'd15;
          ext_d   = 1'b1;
        end else begin
          state_d = ST_ZERO;
          ptr_d   = wi + 4'd1;
          ext_d   = 1'b0;
        end
      end
      ST_ZERO: begin
        if (ext_q) begin
          state_d = ST_LOAD;
          ret_d   = ST_ZERO;
          ptr_d   = 4'd0;
          ext_d   = 1'b0;
        end else if (ptr_q == 4'd14) begin
          state_d = ST_LEN0;
        end else begin
          ptr_d = ptr_q + 4'd1;
        end
      end
      ST_LEN0: state_d = ST_LEN1;
      ST_LEN1: begin
        state_d = ST_LOAD;
        ret_d   = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc && (oidx_q == 3'd7)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    mem_we     = 1'b0;
    waddr      = wi;
    wdata      = {acc_q, data_byte_i};
    in_stall_o = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    comp_start = (state_q == ST_LOAD);
    case (state_q)
      ST_IDLE: mem_we = in_acc && has_byte_i && (count_q[1:0] == 2'd3);
      ST_PAD: begin
        mem_we = 1'b1;
        wdata  = padword;
      end
      ST_ZERO: begin
        mem_we = 1'b1;
        waddr  = ptr_q;
        wdata  = '0;
      end
      ST_LEN0: begin
        mem_we = 1'b1;
        waddr  = 4'd14;
        wdata  = count_q[60:29];
      end
      ST_LEN1: begin
        mem_we = 1'b1;
        waddr  = 4'd15;
        wdata  = {count_q[28:0], 3'b000};
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (state_q == ST_IDLE && in_acc && has_byte_i) begin
      count_d = count_q + {{(CntW-1){1'b0}}, 1'b1};
    end else if (state_q == ST_OUT && out_acc && oidx_q == 3'd7) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      ptr_q   <= '0;
      ext_q   <= 1'b0;
      oidx_q  <= '0;
      count_q <= '0;
      chain_q <= IV_TAB;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      ptr_q   <= ptr_d;
      ext_q   <= ext_d;
      count_q <= count_d;
      if (state_q == ST_COMP && comp_done) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + vars[i];
        end
      end else if (out_acc) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          chain_q <= IV_TAB;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && has_byte_i) begin
      acc_q <= {acc_q[15:0], data_byte_i};
    end
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  shmh_comp u_comp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (comp_start),
    .chain_i (chain_q),
    .rdata_i (rdata_q),
    .raddr_o (raddr),
    .done_o  (comp_done),
    .vars_o  (vars)
  );

  assign digest_word_o = chain_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign final_word_o  = (oidx_q == 3'd7);

endmodule

### hw/rtl/shmh_comp.sv
// ----------------------------------------------------------------------------
// shmh_comp
// 64-round compression engine: message schedule window one round ahead of
// the round logic, message words read from the block memory.
// ----------------------------------------------------------------------------
module shmh_comp
  import shmh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  word_t       chain_i [8],
  input  word_t       rdata_i,
  output logic [3:0]  raddr_o,
  output logic        done_o,
  output word_t       vars_o [8]
);

  logic [6:0] cnt_q;
  logic       busy_q;
  logic       done_q;
  word_t      win_q [16];
  word_t      wk_q;
  word_t      v_q [8];
  word_t      w_new;
  word_t      t1;
  word_t      t2;

  always_comb begin
    if (cnt_q < 7'd16) begin
      w_new = rdata_i;
    end else begin
      w_new = sig1(win_q[14]) + win_q[9] + sig0(win_q[1]) + win_q[0];
    end
    t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + wk_q;
    t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  assign raddr_o = busy_q ? (cnt_q[3:0] + 4'd1) : 4'd0;
  assign done_o  = done_q;
  assign vars_o  = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == 7'd64) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= chain_i;
    end else if (busy_q) begin
      if (!cnt_q[6]) begin
        for (int i = 0; i < 15; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[15] <= w_new;
        wk_q      <= w_new + K_TAB[cnt_q[5:0]];
      end
      if (cnt_q != 7'd0) begin
        v_q[7] <= v_q[6];
        v_q[6] <= v_q[5];
        v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2];
        v_q[2] <= v_q[1];
        v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
      end
    end
  end

endmodule
